@@ hdl/laae_pkg.sv @@
// ----------------------------------------------------------------------------
// laae_pkg
// Shared types and constants of the leveled adaptive arithmetic encoder:
// payload structs, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package laae_pkg;

  // Interval coder constants.
  localparam logic [15:0] HALF        = 16'h8000;
  localparam logic [15:0] QTR1        = 16'h4000;
  localparam logic [15:0] QTR3        = 16'hC000;
  localparam logic [7:0]  PEND_CAP    = 8'd200;
  localparam logic [15:0] LIMIT_RESET = 16'd16383;

  // Register file layout.
  localparam int          PADDR_W           = 3;
  localparam logic [PADDR_W-1:0] REG_RESCALE_LIMIT = 3'd0;

  typedef struct packed {
    logic        action;
    logic [15:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       final_byte;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MD_TOP_GO,
    ST_MD_TOP_WAIT,
    ST_MD_CUM_GO,
    ST_MD_CUM_WAIT,
    ST_NORM,
    ST_EMIT_FIRST,
    ST_EMIT_PEND,
    ST_TERM_LOW,
    ST_UPDATE,
    ST_RESCALE,
    ST_NEXT,
    ST_PAD
  } state_t;

  typedef enum logic [1:0] {
    NORM_EMIT,
    NORM_STRADDLE,
    NORM_DONE
  } norm_kind_t;

  typedef enum logic [1:0] {
    SRC_FIRST,
    SRC_PEND,
    SRC_TERM
  } emit_src_t;

  typedef struct packed {
    logic      clr_step;
    logic      load;
    logic      scan_step;
    logic      md_start;
    logic      md_sel_cum;
    logic      take_top;
    logic      take_cum;
    logic      norm_step;
    logic      emit;
    emit_src_t emit_src;
    logic      upd;
    logic      resc_step;
    logic      next_level;
    logic      pad;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       scan_done;
    logic       md_done;
    norm_kind_t norm_kind;
    logic       emit_ok;
    logic       pend_zero;
    logic       term_last;
    logic       term_level;
    logic       need_resc;
    logic       resc_done;
    logic       last_level;
    logic       finish;
    logic       pad_ok;
  } status_t;

endpackage

@@ hdl/leveled_adaptive_arith_encoder_top.sv @@
// ----------------------------------------------------------------------------
// leveled_adaptive_arith_encoder_top
// Adaptive arithmetic encoder with escape levels; top level with the
// register port.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per value (action 0) or per stream end (action 1).
//   res channel: one item per completed code byte, MSB first; final_byte
//   marks the last byte of a finished stream.
//   An item is taken only while the encoder is idle; it then works on it
//   alone. Each coded level runs the serial count scan up to symbol
//   index idx (idx up to 2^(VALUE_BITS-1)), two passes of the serial
//   multiply-divide unit, the straddle steps, each output bit with the
//   pending bits it releases, one closing normalization check, the update
//   and the level step, plus a rescale pass when the level is rescaled.
//   A value of bit length k codes k+1 levels; a stream end codes
//   VALUE_BITS+1 levels; on its last level it sends its end bits instead
//   of normalizing, at one per cycle while the output is not stalled,
//   then flushes the packer in the pad step. After reset the count
//   memory is set to ones in all VALUE_BITS+1+2^VALUE_BITS entries (65553
//   by default) before the first item; the register port works throughout.
//   When the receiver stalls, one finished byte waits in the output register
//   and the encoder halts at the next byte it completes.
//   rescale_limit (address 0) must be written only while idle; not enforced.
// ----------------------------------------------------------------------------
module leveled_adaptive_arith_encoder_top #(
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  laae_pkg::in_t                  req_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output laae_pkg::out_t                 res_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [laae_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [15:0]       rescale_limit;
  laae_pkg::cmd_t    cmd;
  laae_pkg::status_t status;

  // Register port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rescale_limit <= laae_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == laae_pkg::REG_RESCALE_LIMIT) begin
      rescale_limit <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == laae_pkg::REG_RESCALE_LIMIT) begin
      prdata = {16'd0, rescale_limit};
    end
  end

  laae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  laae_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .req_data      (req_data),
    .rescale_limit (rescale_limit),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_data      (res_data)
  );

endmodule

@@ hdl/laae_muldiv.sv @@
// ----------------------------------------------------------------------------
// laae_muldiv
// Serial multiply-then-divide unit: quot = (range * mult) / divisor, low
// 16 bits. One shift-add step per cycle, then one restoring divide step
// per cycle.
// ----------------------------------------------------------------------------
module laae_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] range,
  input  logic [31:0] mult,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot
);

  localparam int PROD_W    = 48;
  localparam int MUL_STEPS = 17;
  localparam int CNT_W     = $clog2(PROD_W);

  logic              busy;
  logic              div_ph;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  logic [16:0]       rng;
  logic [31:0]       mcand;
  logic [15:0]       dvs;
  logic [15:0]       rem;
  logic [16:0]       trial;
  logic              qbit;

  // One restoring divide step on the next dividend bit.
  always_comb begin
    trial = {rem, prod[PROD_W-1]};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      div_ph <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        div_ph <= 1'b0;
      end else if (busy && !div_ph && cnt == '0) begin
        div_ph <= 1'b1;
      end else if (busy && div_ph && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath of the serial unit.
  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= '0;
      rng   <= range;
      mcand <= mult;
      dvs   <= divisor;
      cnt   <= CNT_W'(MUL_STEPS - 1);
    end else if (busy && !div_ph) begin
      prod <= (prod << 1) + (rng[16] ? PROD_W'(mcand) : '0);
      rng  <= rng << 1;
      rem  <= '0;
      if (cnt == '0) begin
        cnt <= CNT_W'(PROD_W - 1);
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else if (busy) begin
      prod <= prod << 1;
      rem  <= qbit ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      quot <= {quot[14:0], qbit};
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ hdl/laae_datapath.sv @@
// ----------------------------------------------------------------------------
// laae_datapath
// Count memory, level totals, interval coder, bit packer and output register.
// Acts on commands from the controller and reports status back.
// ----------------------------------------------------------------------------
module laae_datapath #(
  parameter int VALUE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  laae_pkg::cmd_t   cmd,
  output laae_pkg::status_t status,
  input  laae_pkg::in_t    req_data,
  input  logic [15:0]      rescale_limit,
  output logic             res_valid,
  input  logic             res_ready,
  output laae_pkg::out_t   res_data
);

  localparam int NUM_LEVELS = VALUE_BITS + 1;
  localparam int LW         = $clog2(NUM_LEVELS);
  localparam int DEPTH      = NUM_LEVELS + (1 << VALUE_BITS);
  localparam int AW         = $clog2(DEPTH);
  localparam int IW         = VALUE_BITS;
  localparam logic [LW-1:0] LAST_LEVEL = LW'(VALUE_BITS);

  // Item and level context.
  logic [VALUE_BITS-1:0] value;
  logic [LW-1:0]         top_k;
  logic [LW-1:0]         level;
  logic                  finish;
  logic [LW-1:0]         load_k;

  // Count storage.
  logic [15:0] totals [NUM_LEVELS];
  logic [15:0] mem [DEPTH];
  logic [15:0] rdata;
  logic [AW-1:0] clr_addr;

  // Serial scan and rescale pass.
  logic [IW-1:0] pos;
  logic          rd_pend;
  logic          rd_last;
  logic [AW-1:0] wb_addr;
  logic [31:0]   cum;
  logic [31:0]   top;
  logic [15:0]   sym_cnt;
  logic [15:0]   resc_sum;

  // Interval coder and packer.
  logic [15:0] low;
  logic [15:0] high;
  logic [15:0] nh;
  logic [7:0]  pending;
  logic        emit_bit;
  logic [3:0]  term_cnt;
  logic [7:0]  acc;
  logic [2:0]  fill;

  // Combinational helpers.
  logic [AW-1:0] level_base;
  logic [IW-1:0] level_size;
  logic [IW-1:0] sym_idx;
  logic          issue;
  logic [AW-1:0] ra;
  logic          re;
  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;
  logic [15:0]   halved;
  logic [16:0]   rangev;
  logic [15:0]   divisor;
  logic [15:0]   quot;
  logic          md_done;
  logic [16:0]   upd_total;
  logic [15:0]   new_low;
  logic [15:0]   norm_low;
  logic [15:0]   norm_high;
  laae_pkg::norm_kind_t norm_kind;
  logic          out_free;
  logic          bit_val;
  logic          bit_fin;
  logic [7:0]    acc_next;
  logic          push;
  logic [7:0]    push_byte;
  logic          push_fin;

  // Bit length of the incoming value picks its last level.
  always_comb begin
    load_k = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (req_data.sample_value[i]) begin
        load_k = LW'(i + 1);
      end
    end
  end

  // Level layout and symbol index within the level.
  always_comb begin
    level_base = (level == '0) ? '0 : AW'(level) + (AW'(1) << (level - 1'b1));
    level_size = (level == '0) ? IW'(2) : IW'(1) + (IW'(1) << (level - 1'b1));
    if (!finish && level == top_k) begin
      sym_idx = (top_k == '0) ? IW'(1)
              : IW'(value - (VALUE_BITS'(1) << (top_k - 1'b1)) + 1'b1);
    end else begin
      sym_idx = '0;
    end
  end

  // Memory port selection.
  always_comb begin
    issue  = cmd.scan_step ? (pos <= sym_idx) : (pos < level_size);
    ra     = level_base + AW'(pos);
    re     = (cmd.scan_step || cmd.resc_step) && issue;
    halved = (rdata[15:1] == '0) ? 16'd1 : {1'b0, rdata[15:1]};
    we     = 1'b0;
    wa     = clr_addr;
    wd     = 16'd1;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.upd) begin
      we = 1'b1;
      wa = level_base + AW'(sym_idx);
      wd = sym_cnt + 16'd1;
    end else if (cmd.resc_step && rd_pend) begin
      we = 1'b1;
      wa = wb_addr;
      wd = halved;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  // Interval arithmetic.
  always_comb begin
    rangev    = {1'b0, 16'(high - low)} + 17'd1;
    divisor   = (totals[level] == '0) ? 16'd1 : totals[level];
    upd_total = {1'b0, totals[level]} + 17'd1;
    new_low   = low + quot;
  end

  laae_muldiv u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.md_start),
    .range   (rangev),
    .mult    (cmd.md_sel_cum ? cum : top),
    .divisor (divisor),
    .done    (md_done),
    .quot    (quot)
  );

  // Normalization decision and the shifted interval.
  always_comb begin
    norm_low  = {low[14:0], 1'b0};
    norm_high = {high[14:0], 1'b1};
    if (high < laae_pkg::HALF || low >= laae_pkg::HALF) begin
      norm_kind = laae_pkg::NORM_EMIT;
    end else if (low >= laae_pkg::QTR1 && high < laae_pkg::QTR3) begin
      // Low sits in the second quarter and high in the third.
      norm_kind = laae_pkg::NORM_STRADDLE;
      norm_low  = {1'b0, low[13:0], 1'b0};
      norm_high = {1'b1, high[13:0], 1'b1};
    end else begin
      norm_kind = laae_pkg::NORM_DONE;
    end
  end

  // Bit packer input and byte completion.
  always_comb begin
    out_free = !res_valid || res_ready;
    case (cmd.emit_src)
      laae_pkg::SRC_FIRST: bit_val = emit_bit;
      laae_pkg::SRC_PEND:  bit_val = !emit_bit;
      default:             bit_val = low[4'(term_cnt - 4'd1)];
    endcase
    bit_fin   = (cmd.emit_src == laae_pkg::SRC_TERM) && (term_cnt == 4'd1);
    acc_next  = {acc[6:0], bit_val};
    push      = (cmd.emit && fill == 3'd7) || (cmd.pad && fill != 3'd0);
    push_byte = cmd.pad ? 8'(acc << (4'd8 - {1'b0, fill})) : acc_next;
    push_fin  = cmd.pad || bit_fin;
  end

  // Status to the controller.
  always_comb begin
    status.clr_done   = (clr_addr == AW'(DEPTH - 1));
    status.scan_done  = rd_pend && rd_last;
    status.md_done    = md_done;
    status.norm_kind  = norm_kind;
    status.emit_ok    = (fill != 3'd7) || out_free;
    status.pend_zero  = (pending == '0);
    status.term_last  = (term_cnt == 4'd1);
    status.term_level = finish && (level == LAST_LEVEL);
    status.need_resc  = (upd_total >= {1'b0, rescale_limit});
    status.resc_done  = !rd_pend && (pos == level_size);
    status.last_level = (level == (finish ? LAST_LEVEL : top_k));
    status.finish     = finish;
    status.pad_ok     = (fill == 3'd0) || out_free;
  end

  // Control and coder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      rd_pend   <= 1'b0;
      low       <= '0;
      high      <= 16'hFFFF;
      pending   <= '0;
      acc       <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        totals[l] <= (l == 0) ? 16'd2 : 16'(1 + (1 << (l - 1)));
      end
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end

      // Output register.
      if (push) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end

      // Serial count scan.
      if (cmd.load || cmd.next_level) begin
        pos     <= '0;
        rd_pend <= 1'b0;
      end else if (cmd.scan_step || cmd.resc_step) begin
        rd_pend <= issue;
        if (issue) begin
          pos <= pos + 1'b1;
        end
      end else if (cmd.upd) begin
        pos     <= '0;
        rd_pend <= 1'b0;
      end

      if (cmd.take_cum) begin
        high <= nh;
        low  <= new_low;
      end

      if (cmd.norm_step) begin
        low  <= norm_low;
        high <= norm_high;
        if (norm_kind == laae_pkg::NORM_STRADDLE &&
            pending < laae_pkg::PEND_CAP) begin
          pending <= pending + 1'b1;
        end
      end

      // Packer.
      if (cmd.emit) begin
        if (cmd.emit_src == laae_pkg::SRC_PEND) begin
          pending <= pending - 1'b1;
        end
        if (fill == 3'd7) begin
          acc  <= '0;
          fill <= '0;
        end else begin
          acc  <= acc_next;
          fill <= fill + 1'b1;
        end
      end

      if (cmd.upd && !status.need_resc) begin
        totals[level] <= upd_total[15:0];
      end
      if (cmd.resc_step && status.resc_done) begin
        totals[level] <= resc_sum;
      end

      // End of stream: coder returns to its reset state.
      if (cmd.pad) begin
        low     <= '0;
        high    <= 16'hFFFF;
        pending <= '0;
        acc     <= '0;
        fill    <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value  <= req_data.sample_value[VALUE_BITS-1:0];
      top_k  <= load_k;
      finish <= req_data.action;
      level  <= '0;
    end else if (cmd.next_level) begin
      level <= level + 1'b1;
    end

    if (cmd.load || cmd.next_level) begin
      cum <= '0;
    end else if (cmd.scan_step && rd_pend) begin
      if (rd_last) begin
        top     <= cum + 32'(rdata);
        sym_cnt <= rdata;
      end else begin
        cum <= cum + 32'(rdata);
      end
    end
    if (cmd.scan_step && issue) begin
      rd_last <= (pos == sym_idx);
    end

    if (cmd.upd) begin
      resc_sum <= '0;
    end else if (cmd.resc_step) begin
      if (issue) begin
        wb_addr <= ra;
      end
      if (rd_pend) begin
        resc_sum <= resc_sum + halved;
      end
    end

    if (cmd.take_top) begin
      nh <= low + quot - 16'd1;
    end
    if (cmd.take_cum) begin
      emit_bit <= new_low[15];
      term_cnt <= 4'd15;
    end
    // The msb of high gives the bit, also for a wrapped interval.
    if (cmd.norm_step && norm_kind == laae_pkg::NORM_EMIT) begin
      emit_bit <= high[15];
    end
    if (cmd.emit && cmd.emit_src == laae_pkg::SRC_TERM) begin
      term_cnt <= term_cnt - 4'd1;
    end

    if (push) begin
      res_data.code_byte  <= push_byte;
      res_data.final_byte <= push_fin;
    end
  end

  // The straddle counter saturates at its cap.
  a_pending_cap: assert property (@(posedge clk) disable iff (rst)
    pending <= laae_pkg::PEND_CAP)
    else $error("pending straddle count above its cap");

  // A byte never overwrites one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (push && res_valid) |-> res_ready)
    else $error("output byte overwritten while stalled");

  // Finishing a stream leaves the coder at its reset interval.
  a_pad_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.pad |=> (fill == 3'd0 && pending == '0 && low == '0 && high == 16'hFFFF))
    else $error("coder not reset after stream end");

endmodule

@@ hdl/laae_ctrl.sv @@
// ----------------------------------------------------------------------------
// laae_ctrl
// Controller state machine: steps each item through the levels, the
// count scan, the interval update, normalization, bit output and the
// count update and rescale, with the clear pass and the pad step.
// ----------------------------------------------------------------------------
module laae_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  laae_pkg::status_t status,
  output laae_pkg::cmd_t    cmd
);

  laae_pkg::state_t state;
  laae_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= laae_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      laae_pkg::ST_CLEAR:       if (status.clr_done) state_next = laae_pkg::ST_IDLE;
      laae_pkg::ST_IDLE:        if (req_valid) state_next = laae_pkg::ST_SCAN;
      laae_pkg::ST_SCAN:        if (status.scan_done) state_next = laae_pkg::ST_MD_TOP_GO;
      laae_pkg::ST_MD_TOP_GO:   state_next = laae_pkg::ST_MD_TOP_WAIT;
      laae_pkg::ST_MD_TOP_WAIT: if (status.md_done) state_next = laae_pkg::ST_MD_CUM_GO;
      laae_pkg::ST_MD_CUM_GO:   state_next = laae_pkg::ST_MD_CUM_WAIT;
      laae_pkg::ST_MD_CUM_WAIT: begin
        if (status.md_done) begin
          state_next = status.term_level ? laae_pkg::ST_EMIT_FIRST : laae_pkg::ST_NORM;
        end
      end
      laae_pkg::ST_NORM: begin
        unique case (status.norm_kind)
          laae_pkg::NORM_EMIT:     state_next = laae_pkg::ST_EMIT_FIRST;
          laae_pkg::NORM_STRADDLE: state_next = laae_pkg::ST_NORM;
          default:                 state_next = laae_pkg::ST_UPDATE;
        endcase
      end
      laae_pkg::ST_EMIT_FIRST:  if (status.emit_ok) state_next = laae_pkg::ST_EMIT_PEND;
      laae_pkg::ST_EMIT_PEND: begin
        if (status.pend_zero) begin
          state_next = status.term_level ? laae_pkg::ST_TERM_LOW : laae_pkg::ST_NORM;
        end
      end
      laae_pkg::ST_TERM_LOW: begin
        if (status.emit_ok && status.term_last) state_next = laae_pkg::ST_UPDATE;
      end
      laae_pkg::ST_UPDATE: begin
        state_next = status.need_resc ? laae_pkg::ST_RESCALE : laae_pkg::ST_NEXT;
      end
      laae_pkg::ST_RESCALE:     if (status.resc_done) state_next = laae_pkg::ST_NEXT;
      laae_pkg::ST_NEXT: begin
        if (!status.last_level) begin
          state_next = laae_pkg::ST_SCAN;
        end else begin
          state_next = status.finish ? laae_pkg::ST_PAD : laae_pkg::ST_IDLE;
        end
      end
      laae_pkg::ST_PAD:         if (status.pad_ok) state_next = laae_pkg::ST_IDLE;
      default:                  state_next = laae_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      laae_pkg::ST_CLEAR:       cmd.clr_step = 1'b1;
      laae_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      laae_pkg::ST_SCAN:        cmd.scan_step = 1'b1;
      laae_pkg::ST_MD_TOP_GO:   cmd.md_start = 1'b1;
      laae_pkg::ST_MD_TOP_WAIT: cmd.take_top = status.md_done;
      laae_pkg::ST_MD_CUM_GO: begin
        cmd.md_start   = 1'b1;
        cmd.md_sel_cum = 1'b1;
      end
      laae_pkg::ST_MD_CUM_WAIT: cmd.take_cum = status.md_done;
      laae_pkg::ST_NORM:        cmd.norm_step = (status.norm_kind != laae_pkg::NORM_DONE);
      laae_pkg::ST_EMIT_FIRST: begin
        cmd.emit     = status.emit_ok;
        cmd.emit_src = laae_pkg::SRC_FIRST;
      end
      laae_pkg::ST_EMIT_PEND: begin
        cmd.emit     = status.emit_ok && !status.pend_zero;
        cmd.emit_src = laae_pkg::SRC_PEND;
      end
      laae_pkg::ST_TERM_LOW: begin
        cmd.emit     = status.emit_ok;
        cmd.emit_src = laae_pkg::SRC_TERM;
      end
      laae_pkg::ST_UPDATE:      cmd.upd = 1'b1;
      laae_pkg::ST_RESCALE:     cmd.resc_step = 1'b1;
      laae_pkg::ST_NEXT:        cmd.next_level = !status.last_level;
      laae_pkg::ST_PAD:         cmd.pad = status.pad_ok;
      default:                  cmd = '0;
    endcase
  end

endmodule
